### hdl/albs_pkg.sv
// Shared types, codes and step tables for the alert light and buzzer sequencer.
`default_nettype none

package albs_pkg;

    // Width of the tick counters
    localparam int COUNT_WIDTH = 12;
    localparam int LEN_WIDTH   = 11;
    localparam int STEP_WIDTH  = 5;
    localparam int ADDR_WIDTH  = 6;

    // Idle blink: green on for the first 100 ms of each 1 s period
    localparam logic [COUNT_WIDTH-1:0] IDLE_ON_TICKS     = COUNT_WIDTH'(400);
    localparam logic [COUNT_WIDTH-1:0] IDLE_PERIOD_TICKS = COUNT_WIDTH'(4000);

    // Request kinds carried in the input tuser
    localparam logic [1:0] MODE_TICK  = 2'd0;
    localparam logic [1:0] MODE_ALERT = 2'd1;
    localparam logic [1:0] MODE_ACK   = 2'd2;

    // Pattern codes
    localparam logic [1:0] PSEL_AMBULANCE = 2'd0;
    localparam logic [1:0] PSEL_POLICE    = 2'd1;
    localparam logic [1:0] PSEL_FIRE      = 2'd2;
    localparam logic [1:0] PSEL_SOS       = 2'd3;

    typedef struct packed {
        logic                 lit;
        logic [LEN_WIDTH-1:0] len;
    } step_t;

    typedef struct packed {
        logic                   active;
        logic                   acked;
        logic [1:0]             pattern;
        logic [STEP_WIDTH-1:0]  step_index;
        logic [COUNT_WIDTH-1:0] step_ticks;
        logic                   police_toggle;
        logic [COUNT_WIDTH-1:0] idle_ticks;
    } state_t;

    typedef struct packed {
        logic running;
        logic buzzer;
        logic green;
        logic red;
    } result_t;

    // Number of steps in each pattern
    function automatic logic [STEP_WIDTH-1:0] pat_count(input logic [1:0] pat);
        logic [STEP_WIDTH-1:0] cnt;
        case (pat)
            PSEL_AMBULANCE: cnt = STEP_WIDTH'(4);
            PSEL_POLICE:    cnt = STEP_WIDTH'(2);
            PSEL_FIRE:      cnt = STEP_WIDTH'(7);
            PSEL_SOS:       cnt = STEP_WIDTH'(21);
            default:        cnt = STEP_WIDTH'(4);
        endcase
        return cnt;
    endfunction

    // First table entry of each pattern
    function automatic logic [ADDR_WIDTH-1:0] pat_offset(input logic [1:0] pat);
        logic [ADDR_WIDTH-1:0] ofs;
        case (pat)
            PSEL_AMBULANCE: ofs = ADDR_WIDTH'(0);
            PSEL_POLICE:    ofs = ADDR_WIDTH'(4);
            PSEL_FIRE:      ofs = ADDR_WIDTH'(6);
            PSEL_SOS:       ofs = ADDR_WIDTH'(13);
            default:        ofs = ADDR_WIDTH'(0);
        endcase
        return ofs;
    endfunction

    // Table address of the current step; an index past the end reads step zero
    function automatic logic [ADDR_WIDTH-1:0] step_addr(input logic [1:0] pat,
                                                        input logic [STEP_WIDTH-1:0] idx);
        logic [STEP_WIDTH-1:0] i;
        i = (idx >= pat_count(pat)) ? '0 : idx;
        return pat_offset(pat) + ADDR_WIDTH'(i);
    endfunction

    // Step table: lit flag and length in ticks
    function automatic step_t step_lookup(input logic [ADDR_WIDTH-1:0] addr);
        step_t s;
        case (addr)
            6'd0, 6'd2:
                s = '{lit: 1'b1, len: LEN_WIDTH'(600)};
            6'd1, 6'd7, 6'd9, 6'd11:
                s = '{lit: 1'b0, len: LEN_WIDTH'(320)};
            6'd3:
                s = '{lit: 1'b0, len: LEN_WIDTH'(1400)};
            6'd4, 6'd6, 6'd8, 6'd10, 6'd13, 6'd15, 6'd17, 6'd27, 6'd29, 6'd31:
                s = '{lit: 1'b1, len: LEN_WIDTH'(400)};
            6'd5, 6'd14, 6'd16, 6'd18, 6'd21, 6'd23, 6'd25, 6'd28, 6'd30, 6'd32:
                s = '{lit: 1'b0, len: LEN_WIDTH'(400)};
            6'd12:
                s = '{lit: 1'b0, len: LEN_WIDTH'(1200)};
            6'd19, 6'd26:
                s = '{lit: 1'b0, len: LEN_WIDTH'(600)};
            6'd20, 6'd22, 6'd24:
                s = '{lit: 1'b1, len: LEN_WIDTH'(1400)};
            6'd33:
                s = '{lit: 1'b0, len: LEN_WIDTH'(2000)};
            default:
                s = '{lit: 1'b0, len: '0};
        endcase
        return s;
    endfunction

endpackage

`default_nettype wire

### hdl/albs_core.sv
// Next-state and output logic of the sequencer for one request.
`default_nettype none

module albs_core
    import albs_pkg::*;
(
    input  wire state_t     st,
    input  wire logic [1:0] mode,
    input  wire logic [2:0] pattern,
    output state_t          st_next,
    output result_t         res
);

    step_t                  cur;
    step_t                  nxt;
    logic [COUNT_WIDTH-1:0] tick_cnt;
    logic [COUNT_WIDTH-1:0] idle_cnt;
    logic [STEP_WIDTH-1:0]  idx_inc;
    logic                   police;

    // Advance the state for this request
    always_comb
    begin
        st_next  = st;
        cur      = step_lookup(step_addr(st.pattern, st.step_index));
        tick_cnt = st.step_ticks + COUNT_WIDTH'(1);
        idle_cnt = st.idle_ticks + COUNT_WIDTH'(1);
        idx_inc  = st.step_index + STEP_WIDTH'(1);

        case (mode)
            MODE_TICK:
            begin
                if (st.acked)
                begin
                    st_next = st;
                end
                else if (st.active)
                begin
                    st_next.step_ticks = tick_cnt;
                    if (tick_cnt >= COUNT_WIDTH'(cur.len))
                    begin
                        st_next.step_ticks = '0;
                        st_next.step_index = idx_inc;
                        if (idx_inc >= pat_count(st.pattern))
                        begin
                            st_next.step_index = '0;
                            if (st.pattern == PSEL_POLICE)
                            begin
                                st_next.police_toggle = ~st.police_toggle;
                            end
                        end
                    end
                end
                else
                begin
                    st_next.idle_ticks = (idle_cnt >= IDLE_PERIOD_TICKS) ? '0 : idle_cnt;
                end
            end
            MODE_ALERT:
            begin
                if (pattern[2] == 1'b0)
                begin
                    st_next.active     = 1'b1;
                    st_next.acked      = 1'b0;
                    st_next.pattern    = pattern[1:0];
                    st_next.step_index = '0;
                    st_next.step_ticks = '0;
                end
                else
                begin
                    // Unknown pattern: drop to idle and restart the blink
                    st_next.active     = 1'b0;
                    st_next.acked      = 1'b0;
                    st_next.idle_ticks = '0;
                end
            end
            MODE_ACK:
            begin
                st_next.acked  = 1'b1;
                st_next.active = 1'b0;
            end
            default:
            begin
                st_next = st;
            end
        endcase
    end

    // Derive the output levels from the updated state
    always_comb
    begin
        nxt    = step_lookup(step_addr(st_next.pattern, st_next.step_index));
        police = (st_next.pattern == PSEL_POLICE);
        res    = '0;
        if (st_next.acked)
        begin
            res.green = 1'b1;
        end
        else if (st_next.active)
        begin
            res.running = 1'b1;
            if (nxt.lit)
            begin
                res.buzzer = ~st_next.step_ticks[0];
                if (police)
                begin
                    res.red   = st_next.police_toggle;
                    res.green = ~st_next.police_toggle;
                end
                else
                begin
                    res.red = 1'b1;
                end
            end
        end
        else
        begin
            res.green = (st_next.idle_ticks < IDLE_ON_TICKS);
        end
    end

endmodule

`default_nettype wire

### hdl/alert_light_buzzer_sequencer_unit.sv
// Top level of the alert light and buzzer sequencer with its stream ports.
`default_nettype none

// Each request is a 250 us tick, an alert with a pattern code, or an acknowledge,
// and each returns one result with the red, green and buzzer levels and a
// pattern-running flag as they stand after that request. A request is captured
// in an input register and then passes through the step table and counter
// logic into the result register once that register is free or being drained;
// one request per clock is sustained while the receiver accepts results. A stalled
// result holds the pipeline only when both stages are full.

module alert_light_buzzer_sequencer_unit
    import albs_pkg::*;
(
    input  wire        clk,
    input  wire        rst_n,
    input  wire        s_axis_tvalid,
    output logic       s_axis_tready,
    input  wire  [7:0] s_axis_tdata,   // [2:0] pattern, [7:3] zero
    input  wire  [1:0] s_axis_tuser,   // [1:0] mode
    output logic       m_axis_tvalid,
    input  wire        m_axis_tready,
    output logic [7:0] m_axis_tdata    // [0] red_on, [1] green_on, [2] buzzer_on,
                                       // [3] pattern_running, [7:4] zero
);

    logic       in_vld_reg;
    logic [1:0] in_mode_reg;
    logic [2:0] in_pattern_reg;
    state_t     state_reg;
    state_t     state_next;
    result_t    res_next;
    logic       out_vld_reg;
    result_t    out_res_reg;
    logic       advance;

    // Move the held request on when the result slot is free or being drained
    assign advance       = in_vld_reg && (!out_vld_reg || m_axis_tready);
    assign s_axis_tready = !in_vld_reg || advance;

    // Capture the incoming request
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            in_vld_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            in_mode_reg    <= s_axis_tuser;
            in_pattern_reg <= s_axis_tdata[2:0];
        end
    end

    albs_core u_core (
        .st      (state_reg),
        .mode    (in_mode_reg),
        .pattern (in_pattern_reg),
        .st_next (state_next),
        .res     (res_next)
    );

    // Update the sequencer state as each request completes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= '0;
        end
        else if (advance)
        begin
            state_reg <= state_next;
        end
    end

    // Hold the result until it is taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_vld_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_res_reg <= res_next;
        end
    end

    assign m_axis_tvalid = out_vld_reg;
    assign m_axis_tdata  = {4'b0000, out_res_reg.running, out_res_reg.buzzer,
                            out_res_reg.green, out_res_reg.red};

    // An acknowledged sequencer never runs a pattern
    a_ack_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(state_reg.acked && state_reg.active))
        else $error("acknowledge and active pattern both set");

    // A running pattern always points inside its own step list
    a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.active |-> (state_reg.step_index < pat_count(state_reg.pattern)))
        else $error("step index beyond pattern length");

    // The idle blink counter wraps within its period
    a_idle_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.idle_ticks < IDLE_PERIOD_TICKS)
        else $error("idle counter outside blink period");

    // Input backpressure only when both stages hold a request
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> (in_vld_reg && out_vld_reg))
        else $error("input stalled with a free stage");

    // A state update always produces a result
    a_result: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> m_axis_tvalid)
        else $error("completed request without result");

endmodule

`default_nettype wire

### test/alert_light_buzzer_sequencer_unit_test.sv
// Self-checking stream testbench for the alert light and buzzer sequencer unit.
`timescale 1ns / 100ps

module alert_light_buzzer_sequencer_unit_test;
    import albs_pkg::*;

    localparam int CLK_PERIOD = 10;

    // Mode code the block does not use; it reports the current levels only
    localparam logic [1:0] MODE_SPARE  = 2'd3;
    // Lowest pattern code that the block does not recognize
    localparam logic [2:0] PAT_UNKNOWN = 3'd4;

    localparam int unsigned ITEM_BUDGET = 450;
    localparam int unsigned CYCLE_LIMIT = 6000000;
    localparam int          TAIL_CYCLES = 8;
    localparam int          MAX_PRINTED = 25;

    // Scoreboard: tracks the sequencer state and holds the pending light levels
    class sequencer_scoreboard;
        bit                   active;
        bit                   acked;
        bit [1:0]             pat_sel;
        bit [STEP_WIDTH-1:0]  step_idx;
        bit [COUNT_WIDTH-1:0] step_cnt;
        bit                   police_red;
        bit [COUNT_WIDTH-1:0] idle_cnt;

        bit          lit_tab[34];
        int unsigned len_tab[34];
        int unsigned first_step[4];
        int unsigned step_total[4];

        result_t     levels_q[$];
        int unsigned errors;
        int unsigned checked;
        int unsigned n_ticks;
        int unsigned n_alerts;
        int unsigned n_acks;
        int unsigned n_spare;

        function new();
            // ambulance, police, fire, then distress in three groups of seven
            lit_tab = '{1, 0, 1, 0,
                        1, 0,
                        1, 0, 1, 0, 1, 0, 0,
                        1, 0, 1, 0, 1, 0, 0,
                        1, 0, 1, 0, 1, 0, 0,
                        1, 0, 1, 0, 1, 0, 0};
            len_tab = '{600, 320, 600, 1400,
                        400, 400,
                        400, 320, 400, 320, 400, 320, 1200,
                        400, 400, 400, 400, 400, 400, 600,
                        1400, 400, 1400, 400, 1400, 400, 600,
                        400, 400, 400, 400, 400, 400, 2000};
            first_step = '{0, 4, 6, 13};
            step_total = '{4, 2, 7, 21};
            active     = 1'b0;
            acked      = 1'b0;
            pat_sel    = '0;
            step_idx   = '0;
            step_cnt   = '0;
            police_red = 1'b0;
            idle_cnt   = '0;
            errors     = 0;
            checked    = 0;
            n_ticks    = 0;
            n_alerts   = 0;
            n_acks     = 0;
            n_spare    = 0;
        endfunction

        // Table entry of the current step; an index past the end reads step zero
        function int unsigned step_entry();
            int unsigned idx;
            idx = step_idx;
            if (idx >= step_total[pat_sel])
                idx = 0;
            return first_step[pat_sel] + idx;
        endfunction

        // Advance the running pattern by one tick
        function void advance_pattern();
            int unsigned e;
            e = step_entry();
            step_cnt = step_cnt + 1'b1;
            if (step_cnt >= len_tab[e])
            begin
                step_cnt = '0;
                step_idx = step_idx + 1'b1;
                if (step_idx >= step_total[pat_sel])
                begin
                    step_idx = '0;
                    if (pat_sel == PSEL_POLICE)
                        police_red = ~police_red;
                end
            end
        endfunction

        // Apply one request and return the levels it leaves behind
        function result_t next_levels(input logic [1:0] mode, input logic [2:0] pat);
            result_t     lv;
            int unsigned e;
            case (mode)
                MODE_TICK:
                begin
                    if (acked)
                        ;
                    else if (active)
                        advance_pattern();
                    else
                    begin
                        idle_cnt = idle_cnt + 1'b1;
                        if (idle_cnt >= IDLE_PERIOD_TICKS)
                            idle_cnt = '0;
                    end
                end
                MODE_ALERT:
                begin
                    if (pat < PAT_UNKNOWN)
                    begin
                        active   = 1'b1;
                        acked    = 1'b0;
                        pat_sel  = pat[1:0];
                        step_idx = '0;
                        step_cnt = '0;
                    end
                    else
                    begin
                        // unknown pattern: drop to idle with the blink restarted
                        active   = 1'b0;
                        acked    = 1'b0;
                        idle_cnt = '0;
                    end
                end
                MODE_ACK:
                begin
                    acked  = 1'b1;
                    active = 1'b0;
                end
                default:
                    ;
            endcase

            lv = '0;
            if (acked)
                lv.green = 1'b1;
            else if (active)
            begin
                e = step_entry();
                lv.running = 1'b1;
                if (lit_tab[e])
                begin
                    lv.buzzer = ~step_cnt[0];
                    if (pat_sel == PSEL_POLICE)
                    begin
                        lv.red   = police_red;
                        lv.green = ~police_red;
                    end
                    else
                        lv.red = 1'b1;
                end
            end
            else
                lv.green = (idle_cnt < IDLE_ON_TICKS);
            return lv;
        endfunction

        // Note an accepted request and queue its expected levels
        function void note_request(input logic [1:0] mode, input logic [2:0] pat);
            case (mode)
                MODE_TICK:  n_ticks++;
                MODE_ALERT: n_alerts++;
                MODE_ACK:   n_acks++;
                default:    n_spare++;
            endcase
            levels_q.push_back(next_levels(mode, pat));
        endfunction

        function int unsigned pending();
            return levels_q.size();
        endfunction

        function int unsigned sent();
            return n_ticks + n_alerts + n_acks + n_spare;
        endfunction

        task report(input int unsigned idx, input string what,
                    input logic [3:0] want, input logic [3:0] got);
            errors++;
            if (errors <= MAX_PRINTED)
                $display("ERROR result %0d: %s expected %0h got %0h at %0t",
                         idx, what, want, got, $time);
        endtask

        // Compare one accepted result with the oldest expectation
        task check_result(input logic [7:0] data);
            result_t want;
            result_t got;
            if (levels_q.size() == 0)
            begin
                report(checked + 1, "result with nothing pending", 4'h0, data[3:0]);
                return;
            end
            want = levels_q.pop_front();
            got  = data[3:0];
            checked++;
            if (got.red !== want.red)
                report(checked, "red_on", 4'(want.red), 4'(got.red));
            if (got.green !== want.green)
                report(checked, "green_on", 4'(want.green), 4'(got.green));
            if (got.buzzer !== want.buzzer)
                report(checked, "buzzer_on", 4'(want.buzzer), 4'(got.buzzer));
            if (got.running !== want.running)
                report(checked, "pattern_running", 4'(want.running), 4'(got.running));
            if (data[7:4] !== 4'h0)
                report(checked, "padding", 4'h0, data[7:4]);
        endtask
    endclass

    logic       clk = 1'b0;
    logic       rst_n;
    logic       s_axis_tvalid;
    wire        s_axis_tready;
    logic [7:0] s_axis_tdata;   // [2:0] pattern, [7:3] zero
    logic [1:0] s_axis_tuser;   // [1:0] mode
    wire        m_axis_tvalid;
    wire        m_axis_tready;
    wire  [7:0] m_axis_tdata;   // [0] red_on, [1] green_on, [2] buzzer_on,
                                // [3] pattern_running, [7:4] zero

    sequencer_scoreboard sb = new();

    alert_light_buzzer_sequencer_unit uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // Receiver stall pattern: a 16-bit mask walked once per cycle, redrawn when its age counter wraps
    logic [15:0] ready_pat = 16'hFFFF;
    logic [3:0]  ready_pos = '0;
    logic [7:0]  ready_age = '0;

    assign m_axis_tready = ready_pat[ready_pos];

    always @(negedge clk)
    begin
        ready_pos <= ready_pos + 1'b1;
        ready_age <= ready_age + 1'b1;
        if (ready_age == 8'hFF)
        begin
            case ($urandom_range(0, 3))
                0:       ready_pat <= 16'hFFFF;
                1:       ready_pat <= 16'($urandom) | 16'($urandom);
                2:       ready_pat <= 16'($urandom) | 16'h0001;
                default: ready_pat <= (16'($urandom) & 16'($urandom)) | 16'h0101;
            endcase
        end
    end

    // Check every result the receiver accepts
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_result(m_axis_tdata);
    end

    // Hard limit on run length
    int unsigned cycle_count = 0;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results pending", cycle_count, sb.pending());
            $display("alert_light_buzzer_sequencer_unit: mismatch");
            $finish;
        end
    end

    int burst_left = 0;
    bit gaps_on    = 1'b1;

    // Open a new burst when the current one is spent, idling first when gaps are on
    task pace_sender();
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 40);
            if (gaps_on)
            begin
                gap = $urandom_range(1, 5);
                @(negedge clk);
                s_axis_tvalid = 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
        end
        burst_left--;
    endtask

    // Present one request and hold it until the block takes it
    task send_request(input logic [1:0] mode, input logic [2:0] pat);
        pace_sender();
        @(negedge clk);
        s_axis_tvalid = 1'b1;
        s_axis_tuser  = mode;
        s_axis_tdata  = {5'b0, pat};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        sb.note_request(mode, pat);
    endtask

    // Send a run of ticks; the pattern field is ignored, so it carries noise
    task send_ticks(input int unsigned n);
        repeat (n) send_request(MODE_TICK, 3'($urandom_range(0, 7)));
    endtask

    // Hold off the sender until every pending result has come back
    task drain_results();
        @(negedge clk);
        s_axis_tvalid = 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    initial
    begin
        int sel;

        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = MODE_TICK;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Idle blink counts from reset
        send_ticks(6);
        send_request(MODE_SPARE, 3'd7);
        // Police across its first step boundary so the lit half gives way to dark
        send_request(MODE_ALERT, {1'b0, PSEL_POLICE});
        send_ticks(401);
        // Alert while running restarts from the first step
        send_request(MODE_ALERT, {1'b0, PSEL_POLICE});
        send_ticks(3);
        // Acknowledge holds green; ticks change nothing
        send_request(MODE_ACK, 3'd0);
        send_ticks(2);
        send_request(MODE_ACK, 3'd7);
        send_request(MODE_SPARE, 3'd0);
        gaps_on = 1'b0;
        send_request(MODE_ALERT, {1'b0, PSEL_AMBULANCE});
        send_ticks(2);
        send_request(MODE_ALERT, {1'b0, PSEL_FIRE});
        send_ticks(2);
        gaps_on = 1'b1;
        send_request(MODE_ALERT, {1'b0, PSEL_SOS});
        send_ticks(2);
        // Unknown codes drop to idle with the blink restarted
        send_request(MODE_ALERT, PAT_UNKNOWN);
        send_ticks(2);
        send_request(MODE_ALERT, 3'd7);
        send_request(MODE_ALERT, 3'd5);
        send_request(MODE_ALERT, 3'd6);
        send_ticks(2);
        drain_results();

        // Random part: alerts followed by short tick runs, with acks and noise mixed in
        while (sb.sent() < ITEM_BUDGET)
        begin
            gaps_on = ($urandom_range(0, 3) != 0);
            sel     = $urandom_range(0, 99);
            if (sel < 55)
                send_request(MODE_ALERT, 3'($urandom_range(0, 3)));
            else if (sel < 70)
                send_request(MODE_ACK, 3'($urandom_range(0, 7)));
            else if (sel < 80)
                send_request(MODE_ALERT, 3'($urandom_range(4, 7)));
            else if (sel < 88)
                send_request(MODE_SPARE, 3'($urandom_range(0, 7)));
            send_ticks($urandom_range(0, 4));
        end

        // Wait out the pipeline, then keep clocking to catch stray results
        drain_results();
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("covered %0d ticks, %0d alerts, %0d acknowledges, %0d unused-mode requests",
                 sb.n_ticks, sb.n_alerts, sb.n_acks, sb.n_spare);
        $display("%0d results checked, %0d errors, %0d cycles",
                 sb.checked, sb.errors, cycle_count);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("alert_light_buzzer_sequencer_unit: match");
        else
            $display("alert_light_buzzer_sequencer_unit: mismatch");
        $finish;
    end

endmodule

### filelist.f
hdl/albs_pkg.sv
hdl/albs_core.sv
hdl/alert_light_buzzer_sequencer_unit.sv
test/alert_light_buzzer_sequencer_unit_test.sv
